// ===== rtl/blp_pkg.sv =====
// Shared types, codes and defaults for the burst latency pairing block.
package blp_pkg;

  localparam int MAX_SPIKES_DEF = 64;
  localparam int TIME_BITS_DEF  = 32;

  localparam int IN_TIME_W = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CMD_W     = 2;
  localparam int NUM_W     = 7;
  localparam int TAU_W     = 33;

  localparam logic [CMD_W-1:0] CMD_SRC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TGT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ISI = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CMP,
    ST_DEC,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic ld_src;
    logic ld_tgt;
    logic start_run;
    logic start_s;
    logic adv;
    logic settle;
    logic take_pair;
    logic push_pend;
    logic next_s;
    logic push_final;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic adv_ok;
    logic pair_ok;
    logic have_pend;
    logic s_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/blp_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module blp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/blp_ctrl.sv =====
// Sequencer for loads and the pairing walk.
module blp_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [blp_pkg::CMD_W-1:0] in_cmd,
  output logic                      in_ready,
  input  blp_pkg::dp_status_t       status,
  output blp_pkg::ctrl_cmd_t        cmd
);

  import blp_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_cmd)
            CMD_SRC: cmd.ld_src = 1'b1;
            CMD_TGT: cmd.ld_tgt = 1'b1;
            CMD_RUN: begin
              cmd.start_run = 1'b1;
              state_next    = status.empty ? ST_FIN : ST_START;
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        cmd.start_s = 1'b1;
        state_next  = ST_CMP;
      end
      ST_CMP: begin
        if (status.adv_ok) begin
          cmd.adv = 1'b1;
        end else begin
          cmd.settle = 1'b1;
          state_next = ST_DEC;
        end
      end
      ST_DEC: begin
        // an earlier pair can only leave once the output register is free
        if (!(status.pair_ok && status.have_pend && !status.out_free)) begin
          cmd.take_pair = status.pair_ok;
          cmd.push_pend = status.pair_ok && status.have_pend;
          if (status.s_last) begin
            state_next = ST_FIN;
          end else begin
            cmd.next_s = 1'b1;
            state_next = ST_CMP;
          end
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.push_final = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/blp_dp.sv =====
// Datapath: spike stores, burst detection, pairing arithmetic, result register.
module blp_dp #(
  parameter int MAX_SPIKES = 64,
  parameter int TW         = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [blp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [blp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [TW-1:0]                 in_time,
  input  blp_pkg::ctrl_cmd_t            cmd,
  output blp_pkg::dp_status_t           status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [blp_pkg::NUM_W-1:0]     out_num,
  output logic [blp_pkg::TAU_W-1:0]     out_tau,
  output logic                          out_pv,
  output logic                          out_ovf,
  output logic                          out_last
);

  import blp_pkg::*;

  localparam int AW = $clog2(MAX_SPIKES);
  localparam int CW = $clog2(MAX_SPIKES + 1);

  logic [CFG_W-1:0] isi_thr, win;
  logic [CW-1:0]    sc, tc, s, t;
  logic [TW-1:0]    prev_s, prev_t;
  logic             seen_s, seen_t, dropped;

  logic [TW-1:0]    tcur, d_r;
  logic [TAU_W-1:0] tau_r, pend_tau;
  logic [CW-1:0]    pend_num, last_t;
  logic             have_pend;

  logic [TW-1:0]    src_rdata, tgt_rdata;
  logic             src_re, tgt_re;
  logic [AW-1:0]    src_raddr, tgt_raddr;

  // burst start detection on the train being loaded
  logic [TW-1:0] prev_sel;
  logic          seen_sel;
  logic [CW-1:0] cnt_sel;
  logic          is_start, has_room;

  assign prev_sel = cmd.ld_src ? prev_s : prev_t;
  assign seen_sel = cmd.ld_src ? seen_s : seen_t;
  assign cnt_sel  = cmd.ld_src ? sc : tc;
  assign is_start = !seen_sel ||
                    ((in_time > prev_sel) && (CFG_W'(in_time - prev_sel) > isi_thr));
  assign has_room = cnt_sel < CW'(MAX_SPIKES);

  // pairing walk
  logic [TW-1:0] st, gap_c, gap_n;
  logic [CW:0]   t_nx1, t_nx2, s_nx1;
  logic          out_free, push;

  assign st     = src_rdata;
  assign gap_c  = (st >= tcur) ? (st - tcur) : (tcur - st);
  assign gap_n  = (st >= tgt_rdata) ? (st - tgt_rdata) : (tgt_rdata - st);
  assign t_nx1  = (CW + 1)'(t) + 1'b1;
  assign t_nx2  = (CW + 1)'(t) + 2'd2;
  assign s_nx1  = (CW + 1)'(s) + 1'b1;
  assign out_free = !out_valid || out_ready;
  assign push     = cmd.push_pend || cmd.push_final;

  assign status.empty     = (sc == '0) || (tc == '0);
  assign status.adv_ok    = (t_nx1 < (CW + 1)'(tc)) && (gap_n <= gap_c);
  assign status.pair_ok   = (CFG_W'(d_r) <= win) && !(have_pend && (last_t == t));
  assign status.have_pend = have_pend;
  assign status.s_last    = s_nx1 >= (CW + 1)'(sc);
  assign status.out_free  = out_free;

  assign src_re    = cmd.start_s || cmd.next_s;
  assign src_raddr = cmd.next_s ? s_nx1[AW-1:0] : '0;
  assign tgt_re    = cmd.start_run ||
                     (cmd.start_s && (t_nx1 < (CW + 1)'(tc))) ||
                     (cmd.adv && (t_nx2 < (CW + 1)'(tc)));
  assign tgt_raddr = cmd.start_run ? '0 : (cmd.start_s ? t_nx1[AW-1:0] : t_nx2[AW-1:0]);

  blp_ram #(.WIDTH(TW), .DEPTH(MAX_SPIKES)) u_src_ram (
    .clk   (clk),
    .we    (cmd.ld_src && is_start && has_room),
    .waddr (sc[AW-1:0]),
    .wdata (in_time),
    .re    (src_re),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  blp_ram #(.WIDTH(TW), .DEPTH(MAX_SPIKES)) u_tgt_ram (
    .clk   (clk),
    .we    (cmd.ld_tgt && is_start && has_room),
    .waddr (tc[AW-1:0]),
    .wdata (in_time),
    .re    (tgt_re),
    .raddr (tgt_raddr),
    .rdata (tgt_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      isi_thr   <= '0;
      win       <= '0;
      sc        <= '0;
      tc        <= '0;
      s         <= '0;
      t         <= '0;
      prev_s    <= '0;
      prev_t    <= '0;
      seen_s    <= 1'b0;
      seen_t    <= 1'b0;
      dropped   <= 1'b0;
      have_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ISI: isi_thr <= cfg_wdata;
          CFG_WIN: win     <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.ld_src) begin
        prev_s <= in_time;
        seen_s <= 1'b1;
        if (is_start) begin
          if (has_room) sc <= sc + 1'b1;
          else          dropped <= 1'b1;
        end
      end
      if (cmd.ld_tgt) begin
        prev_t <= in_time;
        seen_t <= 1'b1;
        if (is_start) begin
          if (has_room) tc <= tc + 1'b1;
          else          dropped <= 1'b1;
        end
      end
      if (cmd.start_run) begin
        s         <= '0;
        t         <= '0;
        have_pend <= 1'b0;
      end
      if (cmd.adv)       t <= t_nx1[CW-1:0];
      if (cmd.next_s)    s <= s_nx1[CW-1:0];
      if (cmd.take_pair) have_pend <= 1'b1;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.push_final) begin
        sc      <= '0;
        tc      <= '0;
        prev_s  <= '0;
        prev_t  <= '0;
        seen_s  <= 1'b0;
        seen_t  <= 1'b0;
        dropped <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start_s || cmd.adv) tcur <= tgt_rdata;
    if (cmd.settle) begin
      d_r   <= gap_c;
      tau_r <= TAU_W'(tcur) - TAU_W'(st);
    end
    if (cmd.take_pair) begin
      pend_tau <= tau_r;
      pend_num <= have_pend ? (pend_num + 1'b1) : CW'(1);
      last_t   <= t;
    end
    if (cmd.push_pend) begin
      out_num  <= NUM_W'(pend_num);
      out_tau  <= pend_tau;
      out_pv   <= 1'b1;
      out_ovf  <= dropped;
      out_last <= 1'b0;
    end else if (cmd.push_final) begin
      out_num  <= have_pend ? NUM_W'(pend_num) : '0;
      out_tau  <= have_pend ? pend_tau : '0;
      out_pv   <= have_pend;
      out_ovf  <= dropped;
      out_last <= 1'b1;
    end
  end

endmodule

// ===== rtl/burst_latency_pairing_top.sv =====
// Loads are accepted while the block is idle. Compute runs setup steps, then a
// compare and a decide step for each source burst start plus a step for each
// target pointer move, and a final step; it is paced by the single read port of
// each spike store, and stalls while the output register is occupied. Input is
// not accepted during a compute run. rst (synchronous) clears counts, flags,
// configuration and the controller; store contents are not cleared.
module burst_latency_pairing_top #(
  parameter int MAX_SPIKES = blp_pkg::MAX_SPIKES_DEF,
  parameter int TIME_BITS  = blp_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [blp_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [blp_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // spike_time[31:0]
  input  logic [1:0]                    s_axis_tuser,  // cmd[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // pair_number[6:0], tau[39:7],
                                                       // overflow[40], zero fill
  output logic                          m_axis_tuser,  // pair_valid
  output logic                          m_axis_tlast   // last
);

  import blp_pkg::*;

  localparam int TW = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;

  ctrl_cmd_t        cmd;
  dp_status_t       status;
  logic [NUM_W-1:0] out_num;
  logic [TAU_W-1:0] out_tau;
  logic             out_ovf;

  blp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_cmd   (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  blp_dp #(.MAX_SPIKES(MAX_SPIKES), .TW(TW)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_time   (s_axis_tdata[TW-1:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_num   (out_num),
    .out_tau   (out_tau),
    .out_pv    (m_axis_tuser),
    .out_ovf   (out_ovf),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_ovf, out_tau, out_num};

`ifndef SYNTHESIS
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_RUN)) |=> !s_axis_tready)
    else $error("input still accepted after compute item");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata[6:0] == '0)))
    else $error("empty answer not a lone final item with number zero");

  a_pair_numbered: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser && (MAX_SPIKES < 128)) |-> (m_axis_tdata[6:0] != '0))
    else $error("pair item carries number zero");

  a_no_push_while_busy: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !(cmd.push_pend || cmd.push_final))
    else $error("result pushed over a waiting item");
`endif

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for burst_latency_pairing_top with a burst and pairing model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import blp_pkg::*;

  localparam int SPIKES       = MAX_SPIKES_DEF;
  localparam int ITEM_GOAL    = 330;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;  // not decoded by the block
  localparam int SRC = 0;
  localparam int TGT = 1;

  typedef struct {
    logic [NUM_W-1:0] num;
    logic [TAU_W-1:0] tau;
    logic             valid;
    logic             ovf;
    logic             last;
  } pair_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata = '0;
  logic [1:0]           s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  // mirror of the block state
  logic [31:0] isi_thr;
  logic [31:0] win_size;
  logic [31:0] burst_starts [2][SPIKES];
  int          start_cnt [2];
  logic [31:0] prev_time [2];
  bit          train_seen [2];
  bit          drop_flag;

  pair_result_t pending_pairs[$];

  bit pace_on = 1'b1;
  int fail_count = 0;
  int n_items = 0;
  int n_runs = 0;
  int n_ovf_runs = 0;
  int n_results = 0;
  int n_pairs = 0;

  burst_latency_pairing_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] span(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void clear_trains();
    for (int k = 0; k < 2; k++) begin
      start_cnt[k]  = 0;
      prev_time[k]  = '0;
      train_seen[k] = 1'b0;
    end
    drop_flag = 1'b0;
  endfunction

  function automatic void track_spike(int tr, logic [31:0] t);
    bit opens;
    opens = !train_seen[tr] || ((t > prev_time[tr]) && ((t - prev_time[tr]) > isi_thr));
    if (opens) begin
      if (start_cnt[tr] < SPIKES) begin
        burst_starts[tr][start_cnt[tr]] = t;
        start_cnt[tr]++;
      end else begin
        drop_flag = 1'b1;
      end
    end
    prev_time[tr]  = t;
    train_seen[tr] = 1'b1;
  endfunction

  // Walk source starts, target pointer only moves forward.
  function automatic void pair_bursts();
    logic [TAU_W-1:0] taus[$];
    logic [31:0]      st, tt, cur, nxt;
    pair_result_t     r;
    int               t, last_t;
    bit               have_last;
    t = 0;
    last_t = 0;
    have_last = 1'b0;
    if (start_cnt[SRC] > 0 && start_cnt[TGT] > 0) begin
      for (int s = 0; s < start_cnt[SRC]; s++) begin
        st = burst_starts[SRC][s];
        while (t + 1 < start_cnt[TGT]) begin
          cur = span(st, burst_starts[TGT][t]);
          nxt = span(st, burst_starts[TGT][t+1]);
          if (nxt <= cur) t++;
          else break;
        end
        tt = burst_starts[TGT][t];
        if (span(tt, st) > win_size) continue;
        if (have_last && last_t == t) continue;  // same target twice in a row
        taus.push_back({1'b0, tt} - {1'b0, st});
        have_last = 1'b1;
        last_t = t;
      end
    end
    n_runs++;
    if (drop_flag) n_ovf_runs++;
    if (taus.size() == 0) begin
      r.num = '0; r.tau = '0; r.valid = 1'b0; r.ovf = drop_flag; r.last = 1'b1;
      pending_pairs.push_back(r);
    end else begin
      for (int k = 0; k < taus.size(); k++) begin
        r.num   = NUM_W'(k + 1);
        r.tau   = taus[k];
        r.valid = 1'b1;
        r.ovf   = drop_flag;
        r.last  = (k == taus.size() - 1);
        pending_pairs.push_back(r);
      end
    end
    clear_trains();
  endfunction

  task automatic issue_cmd(logic [CMD_W-1:0] c, logic [31:0] t);
    @(negedge clk);
    while (pace_on && $urandom_range(99) < 19) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = c;
    s_axis_tdata  = t;
    do @(posedge clk); while (!s_axis_tready);
    n_items++;
    case (c)
      CMD_SRC: track_spike(SRC, t);
      CMD_TGT: track_spike(TGT, t);
      CMD_RUN: pair_bursts();
      default: ;
    endcase
  endtask

  // Stop sending and wait for all results, then let the bench drain quietly.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    settle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_ISI) isi_thr = val;
    else win_size = val;
  endtask

  function automatic logic [31:0] pick_reg_value();
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 40);
      3: return $urandom_range(0, 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] next_gap();
    case ($urandom_range(7))
      0: return $urandom_range(0, 3000);
      1: return $urandom;
      default: return $urandom_range(0, 60);
    endcase
  endfunction

  function automatic void check_field(string name, logic [TAU_W-1:0] want, logic [TAU_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(negedge clk) begin
    m_axis_tready = pace_on ? ($urandom_range(99) >= 19) : 1'b1;
  end

  always @(posedge clk) begin
    pair_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pairs.size() == 0) begin
        $error("result item with no expectation pending");
        fail_count++;
      end else begin
        want = pending_pairs.pop_front();
        check_field("pair_number", TAU_W'(want.num), TAU_W'(m_axis_tdata[6:0]));
        check_field("tau", want.tau, m_axis_tdata[39:7]);
        check_field("overflow", TAU_W'(want.ovf), TAU_W'(m_axis_tdata[40]));
        check_field("pair_valid", TAU_W'(want.valid), TAU_W'(m_axis_tuser));
        check_field("last", TAU_W'(want.last), TAU_W'(m_axis_tlast));
        n_results++;
        if (want.valid) n_pairs++;
      end
    end
  end

  task automatic test_directed();
    issue_cmd(CMD_RUN, 32'd0);            // empty trains after reset
    issue_cmd(CMD_NONE, 32'hA5A5_5A5A);
    write_reg(CFG_ISI, 32'd10);
    write_reg(CFG_WIN, 32'd20);
    issue_cmd(CMD_SRC, 32'd100);
    issue_cmd(CMD_SRC, 32'd105);          // inside burst
    issue_cmd(CMD_TGT, 32'd95);
    issue_cmd(CMD_SRC, 32'd200);
    issue_cmd(CMD_SRC, 32'd150);          // time going backward
    issue_cmd(CMD_TGT, 32'd110);
    issue_cmd(CMD_TGT, 32'd205);
    issue_cmd(CMD_RUN, 32'd0);
    issue_cmd(CMD_SRC, 32'd7);            // target train empty
    issue_cmd(CMD_RUN, 32'd0);
    issue_cmd(CMD_SRC, 32'd1000);
    issue_cmd(CMD_SRC, 32'd1020);
    issue_cmd(CMD_TGT, 32'd1010);         // both sources want this target
    issue_cmd(CMD_RUN, 32'd0);
    write_reg(CFG_ISI, 32'hFFFF_FFFF);
    write_reg(CFG_WIN, 32'hFFFF_FFFF);
    issue_cmd(CMD_SRC, 32'd0);
    issue_cmd(CMD_SRC, 32'hFFFF_FFFF);
    issue_cmd(CMD_TGT, 32'hFFFF_FFFF);
    issue_cmd(CMD_RUN, 32'd0);
    issue_cmd(CMD_SRC, 32'hFFFF_FFFF);
    issue_cmd(CMD_TGT, 32'd0);
    issue_cmd(CMD_NONE, 32'd0);
    issue_cmd(CMD_RUN, 32'hFFFF_FFFF);
    write_reg(CFG_WIN, 32'd0);
    issue_cmd(CMD_SRC, 32'd5);
    issue_cmd(CMD_TGT, 32'd5);
    issue_cmd(CMD_TGT, 32'd6);
    issue_cmd(CMD_RUN, 32'd0);
  endtask

  // Fills the source store past capacity and the target store at least to capacity, so a run can give its most results.
  task automatic test_store_full();
    logic [31:0] t;
    int          n_src, n_tgt;
    pace_on = 1'b0;
    write_reg(CFG_ISI, 32'd0);
    write_reg(CFG_WIN, 32'hFFFF_FFFF);
    n_src = SPIKES + $urandom_range(1, 4);
    n_tgt = $urandom_range(1) ? SPIKES : SPIKES + $urandom_range(1, 3);
    t = $urandom_range(0, 1000);
    for (int k = 0; k < n_src || k < n_tgt; k++) begin
      if (k < n_src) issue_cmd(CMD_SRC, t);
      if (k < n_tgt) issue_cmd(CMD_TGT, t + $urandom_range(0, 3));
      t = t + $urandom_range(5, 500);
    end
    issue_cmd(CMD_RUN, $urandom);
    settle();
    pace_on = 1'b1;
  endtask

  task automatic test_random_runs();
    logic [31:0] src_t[$];
    logic [31:0] tgt_t[$];
    logic [31:0] t;
    int          len;
    while (n_items < ITEM_GOAL) begin
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_ISI, pick_reg_value());
        write_reg(CFG_WIN, pick_reg_value());
      end
      pace_on = ($urandom_range(4) != 0);
      if ($urandom_range(9) == 0) begin
        // noise: any command, any time
        len = $urandom_range(1, 8);
        repeat (len) issue_cmd(CMD_W'($urandom_range(3)), $urandom);
        if ($urandom_range(1)) issue_cmd(CMD_RUN, $urandom);
      end else begin
        src_t.delete();
        tgt_t.delete();
        t = ($urandom_range(4) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
        len = $urandom_range(0, 10);
        for (int k = 0; k < len; k++) begin
          src_t.push_back(t);
          t = t + next_gap();
        end
        t = (src_t.size() != 0) ? src_t[0] + $urandom_range(0, 60) - 32'd30 : $urandom;
        len = $urandom_range(0, 10);
        for (int k = 0; k < len; k++) begin
          tgt_t.push_back(t);
          t = t + next_gap();
        end
        while (src_t.size() != 0 || tgt_t.size() != 0) begin
          if ($urandom_range(99) < 8) issue_cmd(CMD_NONE, $urandom);
          if (tgt_t.size() == 0 || (src_t.size() != 0 && $urandom_range(1)))
            issue_cmd(CMD_SRC, src_t.pop_front());
          else
            issue_cmd(CMD_TGT, tgt_t.pop_front());
        end
        issue_cmd(CMD_RUN, $urandom);
      end
      if ($urandom_range(5) == 0) settle();
    end
    pace_on = 1'b1;
  endtask

  initial begin
    isi_thr  = '0;
    win_size = '0;
    clear_trains();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_store_full();
    test_random_runs();
    settle();
    $display("Run covered %0d input items, %0d compute runs (%0d with dropped starts),",
             n_items, n_runs, n_ovf_runs);
    $display("and checked %0d result items, %0d of them carrying a pair.", n_results, n_pairs);
    if (fail_count == 0) begin
      $display("** burst_latency_pairing_top: PASSED **");
    end else begin
      $display("** burst_latency_pairing_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** burst_latency_pairing_top: FAILED **");
    $finish;
  end

endmodule
